[sv/lrusc_pkg.sv]
// Shared types, codes and helpers for the LRU set-associative cache model.
package lrusc_pkg;

    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int OP_W         = 2;
    localparam int ADDR_W       = 32;
    localparam int COUNT_W      = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] v,
                                                   input logic [1:0] inc);
        logic [COUNT_W:0] sum;
        sum = {1'b0, v} + (COUNT_W + 1)'(inc);
        return sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    endfunction

endpackage

[sv/lrusc_way_sel.sv]
// Way selection for one set: hit search, first free way, LRU victim, rank update.
module lrusc_way_sel #(
    parameter int MAX_WAYS      = 8,
    parameter int ADDRESS_WIDTH = 32,
    parameter int RANK_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    parameter int WAY_CNT_W     = $clog2(MAX_WAYS + 1)
) (
    input  logic [WAY_CNT_W-1:0]                      i_ways,
    input  logic [ADDRESS_WIDTH-1:0]                  i_tag,
    input  logic [MAX_WAYS-1:0]                       i_valid,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]           i_rank,
    input  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0]    i_tags,
    output lrusc_pkg::t_outcome                       o_outcome,
    output logic [RANK_W-1:0]                         o_way,
    output logic [MAX_WAYS-1:0]                       o_valid,
    output logic [MAX_WAYS-1:0][RANK_W-1:0]           o_rank
);
    import lrusc_pkg::*;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
    localparam logic [RANK_W:0]   AGE_ALL  = (RANK_W + 1)'(MAX_WAYS);

    logic [MAX_WAYS-1:0] w_in_use;
    logic [MAX_WAYS-1:0] w_hit_vec;
    logic [MAX_WAYS-1:0] w_free_vec;
    logic [RANK_W-1:0]   w_hit_way;
    logic [RANK_W-1:0]   w_free_way;
    logic [RANK_W-1:0]   w_vic_way;
    logic [RANK_W-1:0]   w_best;
    logic [RANK_W:0]     w_limit;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_in_use[i]   = (WAY_CNT_W'(i) < i_ways);
            w_hit_vec[i]  = w_in_use[i] && i_valid[i] && (i_tags[i] == i_tag);
            w_free_vec[i] = w_in_use[i] && !i_valid[i];
        end
        // lowest matching / free way wins
        w_hit_way  = '0;
        w_free_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (w_hit_vec[i]) begin
                w_hit_way = RANK_W'(i);
            end
            if (w_free_vec[i]) begin
                w_free_way = RANK_W'(i);
            end
        end
        // largest rank, lowest way on a tie
        w_best    = i_rank[0];
        w_vic_way = '0;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (w_in_use[i] && (i_rank[i] > w_best)) begin
                w_best    = i_rank[i];
                w_vic_way = RANK_W'(i);
            end
        end
    end

    always_comb begin
        priority if (|w_hit_vec) begin
            o_outcome = OUT_HIT;
            o_way     = w_hit_way;
            w_limit   = {1'b0, i_rank[w_hit_way]};
        end else if (|w_free_vec) begin
            o_outcome = OUT_FILL;
            o_way     = w_free_way;
            w_limit   = AGE_ALL;
        end else begin
            o_outcome = OUT_EVICT;
            o_way     = w_vic_way;
            w_limit   = {1'b0, w_best};
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            o_rank[i]  = i_rank[i];
            o_valid[i] = i_valid[i];
            if (RANK_W'(i) == o_way) begin
                o_rank[i]  = '0;
                o_valid[i] = 1'b1;
            end else if (w_in_use[i] && i_valid[i] && ({1'b0, i_rank[i]} < w_limit)) begin
                o_rank[i] = (i_rank[i] >= RANK_MAX) ? RANK_MAX : i_rank[i] + 1'b1;
            end
        end
    end

endmodule

[sv/lru_set_associative_cache_sim.sv]
// Set-associative cache with exact LRU replacement, one trace access per item.
// For each item, the set's row (tags, valid bits and recency ranks of all ways) is read
// from a synchronous memory into a register on accept, then compared, updated and
// written back in the lookup state. A modify's second lookup always hits and is
// resolved in the same cycle. The next item is accepted while a result waits in the
// output register, but its write-back waits until that result is taken. After reset
// a clearing pass over every set zeroes the valid bits and ranks; no item is
// accepted during it.
module lru_set_associative_cache_sim #(
    parameter int MAX_SET_BITS  = 6,
    parameter int MAX_WAYS      = 8,
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lrusc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrusc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lrusc_pkg::OP_W-1:0]       i_operation,
    input  logic [lrusc_pkg::ADDR_W-1:0]     i_address,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_outcome,
    output logic                             o_second_hit,
    output logic [lrusc_pkg::COUNT_W-1:0]    o_hit_total,
    output logic [lrusc_pkg::COUNT_W-1:0]    o_miss_total,
    output logic [lrusc_pkg::COUNT_W-1:0]    o_eviction_total
);
    import lrusc_pkg::*;

    localparam int NUM_SETS   = 1 << MAX_SET_BITS;
    localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W  = $clog2(MAX_WAYS + 1);
    localparam int META_W     = MAX_WAYS * (1 + RANK_W);
    localparam int TAGROW_W   = MAX_WAYS * ADDRESS_WIDTH;
    localparam int ADDR_EXT_W = (ADDRESS_WIDTH > ADDR_W) ? ADDRESS_WIDTH : ADDR_W;

    // config
    logic [SET_BITS_W-1:0]   r_set_bits;
    logic [BLOCK_BITS_W-1:0] r_block_bits;
    logic [WAYS_W-1:0]       r_ways;

    // control
    t_state           r_state;
    t_state           n_state;
    logic [SET_W-1:0] r_clr_idx;
    logic             r_out_valid;
    logic             w_clear_we;
    logic             w_accept;
    logic             w_commit;
    logic             w_slot_free;

    // item in flight
    logic [OP_W-1:0]          r_op;
    logic [SET_W-1:0]         r_set;
    logic [ADDRESS_WIDTH-1:0] r_tag;

    // results
    t_outcome           r_outcome;
    logic               r_second;
    logic [COUNT_W-1:0] r_hits;
    logic [COUNT_W-1:0] r_misses;
    logic [COUNT_W-1:0] r_evictions;

    // memories
    logic [META_W-1:0]   mem_meta [NUM_SETS];
    logic [TAGROW_W-1:0] mem_tag  [NUM_SETS];
    logic [META_W-1:0]   r_rd_meta;
    logic [TAGROW_W-1:0] r_rd_tag;

    // address split
    logic [ADDR_EXT_W-1:0]    w_addr_ext;
    logic [ADDRESS_WIDTH-1:0] w_addr;
    logic [3:0]               w_s;
    logic [5:0]               w_sb;
    logic [ADDRESS_WIDTH-1:0] w_set_full;
    logic [SET_W-1:0]         w_set;
    logic [ADDRESS_WIDTH-1:0] w_tag;
    logic [WAY_CNT_W-1:0]     w_ways;

    // way selection
    logic [MAX_WAYS-1:0]                    w_rd_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]        w_rd_rank;
    logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] w_rd_tags;
    t_outcome                               w_sel_outcome;
    logic [RANK_W-1:0]                      w_sel_way;
    logic [MAX_WAYS-1:0]                    w_new_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]        w_new_rank;
    logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] w_new_tags;
    logic                                   w_access;
    logic                                   w_modify;
    logic [1:0]                             w_hit_inc;
    logic [1:0]                             w_miss_inc;
    logic [1:0]                             w_evict_inc;

    assign w_addr_ext = ADDR_EXT_W'(i_address);
    assign w_addr     = w_addr_ext[ADDRESS_WIDTH-1:0];
    assign w_s        = (r_set_bits > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, r_set_bits};
    assign w_sb       = 6'(w_s) + 6'(r_block_bits);
    assign w_set_full = (w_addr >> r_block_bits) & ~({ADDRESS_WIDTH{1'b1}} << w_s);
    assign w_set      = w_set_full[SET_W-1:0];
    assign w_tag      = w_addr >> w_sb;

    always_comb begin
        if (r_ways == '0) begin
            w_ways = WAY_CNT_W'(1);
        end else if (r_ways > MAX_WAYS) begin
            w_ways = WAY_CNT_W'(MAX_WAYS);
        end else begin
            w_ways = WAY_CNT_W'(r_ways);
        end
    end

    // control FSM
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == SET_W'(NUM_SETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_clear_we = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            S_CLEAR: w_clear_we = 1'b1;
            S_IDLE:  o_in_ready = 1'b1;
            S_LOOK:  w_commit   = w_slot_free;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (w_clear_we) r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= WAYS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_operation;
            r_set <= w_set;
            r_tag <= w_tag;
        end
    end

    // set memories: read on accept, write back when an access commits, zero meta while clearing
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_meta <= mem_meta[w_set];
            r_rd_tag  <= mem_tag[w_set];
        end
        if (w_clear_we) begin
            mem_meta[r_clr_idx] <= '0;
        end else if (w_commit && w_access) begin
            mem_meta[r_set] <= {w_new_rank, w_new_valid};
            mem_tag[r_set]  <= w_new_tags;
        end
    end

    assign w_rd_valid = r_rd_meta[MAX_WAYS-1:0];
    assign w_rd_rank  = r_rd_meta[META_W-1:MAX_WAYS];
    assign w_rd_tags  = r_rd_tag;

    lrusc_way_sel #(
        .MAX_WAYS      (MAX_WAYS),
        .ADDRESS_WIDTH (ADDRESS_WIDTH),
        .RANK_W        (RANK_W),
        .WAY_CNT_W     (WAY_CNT_W)
    ) u_way_sel (
        .i_ways    (w_ways),
        .i_tag     (r_tag),
        .i_valid   (w_rd_valid),
        .i_rank    (w_rd_rank),
        .i_tags    (w_rd_tags),
        .o_outcome (w_sel_outcome),
        .o_way     (w_sel_way),
        .o_valid   (w_new_valid),
        .o_rank    (w_new_rank)
    );

    always_comb begin
        w_new_tags            = w_rd_tags;
        w_new_tags[w_sel_way] = r_tag;
    end

    assign w_access = (r_op == OP_LOAD) || (r_op == OP_STORE) || (r_op == OP_MODIFY);
    assign w_modify = (r_op == OP_MODIFY);

    // a modify adds one hit for its second lookup
    always_comb begin
        w_hit_inc   = {1'b0, w_modify};
        w_miss_inc  = 2'd0;
        w_evict_inc = 2'd0;
        unique case (w_sel_outcome)
            OUT_HIT:   w_hit_inc   = w_modify ? 2'd2 : 2'd1;
            OUT_FILL:  w_miss_inc  = 2'd1;
            OUT_EVICT: begin
                w_miss_inc  = 2'd1;
                w_evict_inc = 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evictions <= '0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
            if (w_access) begin
                r_hits      <= sat_add(r_hits, w_hit_inc);
                r_misses    <= sat_add(r_misses, w_miss_inc);
                r_evictions <= sat_add(r_evictions, w_evict_inc);
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_outcome <= w_access ? w_sel_outcome : OUT_HIT;
            r_second  <= w_access && w_modify;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_outcome;
    assign o_second_hit     = r_second;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evictions;

    // every eviction is also a miss
    a_evict_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evictions <= r_misses)
        else $error("eviction total above miss total");

    a_hits_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hits >= $past(r_hits)))
        else $error("hit total decreased");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("result not presented after write-back");

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear_we |-> !w_accept && !w_commit)
        else $error("item handled during clearing pass");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the LRU set-associative cache block.
`timescale 1ns / 1ps

module testbench;

    import lrusc_pkg::*;

    localparam int SET_LIMIT = 6;
    localparam int WAY_LIMIT = 8;
    localparam int NUM_SETS  = 1 << SET_LIMIT;
    localparam int RAND_PER_GEOMETRY = 210;
    localparam int NUM_GEOMETRIES    = 9;

    // operation code 3 makes no access
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         outcome;
        logic               second_hit;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] misses;
        logic [COUNT_W-1:0] evictions;
    } t_access_result;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        logic [OP_W-1:0]       op;
        logic [ADDR_W-1:0]     addr;
        bit                    typed;
        t_outcome              outcome;
        bit                    second_hit;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation = '0;
    logic [ADDR_W-1:0]     i_address = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [1:0]            o_outcome;
    logic                  o_second_hit;
    logic [COUNT_W-1:0]    o_hit_total;
    logic [COUNT_W-1:0]    o_miss_total;
    logic [COUNT_W-1:0]    o_eviction_total;

    // fixed expectation carried alongside a directed item
    logic     dir_typed = 1'b0;
    t_outcome dir_outcome = OUT_HIT;
    logic     dir_second = 1'b0;

    // predictor state
    logic [SET_BITS_W-1:0]   cfg_set_bits = '0;
    logic [BLOCK_BITS_W-1:0] cfg_block_bits = '0;
    logic [WAYS_W-1:0]       cfg_ways = 4'd1;
    logic                    way_valid [NUM_SETS][WAY_LIMIT];
    logic [ADDR_W-1:0]       way_tag   [NUM_SETS][WAY_LIMIT];
    logic [2:0]              way_age   [NUM_SETS][WAY_LIMIT];
    logic [COUNT_W-1:0]      hit_count = '0;
    logic [COUNT_W-1:0]      miss_count = '0;
    logic [COUNT_W-1:0]      evict_count = '0;

    t_access_result pending_results [$];
    t_stim_row      dir_rows [$];

    int send_idle_pct = 18;
    int recv_idle_pct = 64;
    int mismatch_count = 0;
    int checked_count = 0;
    int hit_seen = 0;
    int fill_seen = 0;
    int evict_seen = 0;
    int second_seen = 0;

    int       geo_set   [NUM_GEOMETRIES] = '{0, 1, 3, 6, 6, 2, 7, 4, 5};
    int       geo_block [NUM_GEOMETRIES] = '{0, 2, 5, 26, 0, 3, 10, 31, 8};
    int       geo_ways  [NUM_GEOMETRIES] = '{1, 2, 4, 8, 8, 3, 15, 5, 0};

    lru_set_associative_cache_sim #(
        .MAX_SET_BITS  (SET_LIMIT),
        .MAX_WAYS      (WAY_LIMIT),
        .ADDRESS_WIDTH (ADDR_W)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_address        (i_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_outcome        (o_outcome),
        .o_second_hit     (o_second_hit),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        foreach (way_valid[s, w]) begin
            way_valid[s][w] = 1'b0;
            way_tag[s][w]   = '0;
            way_age[s][w]   = '0;
        end
    end

    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // way w becomes most recent; valid ways younger than limit get one step older
    function automatic void promote_way(input int set_idx, input int nways, input int w,
                                        input int limit);
        for (int i = 0; i < nways; i++) begin
            if (i != w && way_valid[set_idx][i] && int'(way_age[set_idx][i]) < limit) begin
                if (way_age[set_idx][i] != 3'd7)
                    way_age[set_idx][i] = way_age[set_idx][i] + 3'd1;
            end
        end
        way_age[set_idx][w] = '0;
    endfunction

    function automatic t_outcome probe_set(input logic [ADDR_W-1:0] addr);
        int s_eff;
        int nways;
        int sb;
        int set_idx;
        int victim;
        int oldest;
        logic [ADDR_W-1:0] tag;
        s_eff = (int'(cfg_set_bits) > SET_LIMIT) ? SET_LIMIT : int'(cfg_set_bits);
        nways = (cfg_ways == 0) ? 1 : ((int'(cfg_ways) > WAY_LIMIT) ? WAY_LIMIT : int'(cfg_ways));
        sb = s_eff + int'(cfg_block_bits);
        set_idx = int'((addr >> cfg_block_bits) & ((32'd1 << s_eff) - 32'd1));
        tag = (sb >= ADDR_W) ? '0 : (addr >> sb);
        for (int i = 0; i < nways; i++) begin
            if (way_valid[set_idx][i] && way_tag[set_idx][i] == tag) begin
                promote_way(set_idx, nways, i, int'(way_age[set_idx][i]));
                hit_count = count_up(hit_count);
                return OUT_HIT;
            end
        end
        miss_count = count_up(miss_count);
        for (int i = 0; i < nways; i++) begin
            if (!way_valid[set_idx][i]) begin
                way_valid[set_idx][i] = 1'b1;
                way_tag[set_idx][i]   = tag;
                promote_way(set_idx, nways, i, WAY_LIMIT);
                return OUT_FILL;
            end
        end
        // oldest way goes; lowest index wins a tie
        victim = 0;
        oldest = int'(way_age[set_idx][0]);
        for (int i = 1; i < nways; i++) begin
            if (int'(way_age[set_idx][i]) > oldest) begin
                oldest = int'(way_age[set_idx][i]);
                victim = i;
            end
        end
        evict_count = count_up(evict_count);
        way_tag[set_idx][victim] = tag;
        promote_way(set_idx, nways, victim, oldest);
        return OUT_EVICT;
    endfunction

    function automatic t_access_result predict_access(input logic [OP_W-1:0] op,
                                                      input logic [ADDR_W-1:0] addr);
        t_access_result r;
        r.outcome = OUT_HIT;
        r.second_hit = 1'b0;
        if (op != OP_UNUSED) begin
            r.outcome = probe_set(addr);
            if (op == OP_MODIFY)
                r.second_hit = (probe_set(addr) == OUT_HIT);
        end
        r.hits = hit_count;
        r.misses = miss_count;
        r.evictions = evict_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s of result %0d: expected %h, got %h",
                         name, checked_count, want, got);
        end
    endfunction

    // result check first, then prediction of a newly accepted item
    always @(posedge i_clk) begin : scoreboard
        t_access_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result with no item outstanding: outcome %0d hits %0d",
                                 o_outcome, o_hit_total);
                end else begin
                    want = pending_results.pop_front();
                    check_field("outcome", 32'(want.outcome), 32'(o_outcome));
                    check_field("second_hit", 32'(want.second_hit), 32'(o_second_hit));
                    check_field("hit_total", want.hits, o_hit_total);
                    check_field("miss_total", want.misses, o_miss_total);
                    check_field("eviction_total", want.evictions, o_eviction_total);
                    checked_count++;
                    case (o_outcome)
                        OUT_HIT:   hit_seen++;
                        OUT_FILL:  fill_seen++;
                        OUT_EVICT: evict_seen++;
                        default:   ;
                    endcase
                    if (o_second_hit)
                        second_seen++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = predict_access(i_operation, i_address);
                if (dir_typed) begin
                    want.outcome = dir_outcome;
                    want.second_hit = dir_second;
                end
                pending_results.push_back(want);
            end
        end
    end

    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // drop valid, then wait on the clock until no result is pending, the last accepted item included
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SET_BITS:   cfg_set_bits = data[SET_BITS_W-1:0];
            CFG_BLOCK_BITS: cfg_block_bits = data[BLOCK_BITS_W-1:0];
            CFG_WAYS:       cfg_ways = data[WAYS_W-1:0];
            default:        ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input bit typed, input t_outcome outc, input bit second);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_address <= addr;
        dir_typed <= typed;
        dir_outcome <= outc;
        dir_second <= second;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row r;
        r = '{1'b1, idx, data, OP_LOAD, '0, 1'b0, OUT_HIT, 1'b0};
        return r;
    endfunction

    function automatic t_stim_row known_row(input logic [OP_W-1:0] op,
                                            input logic [ADDR_W-1:0] addr,
                                            input t_outcome outc, input bit second);
        t_stim_row r;
        r = '{1'b0, CFG_SET_BITS, '0, op, addr, 1'b1, outc, second};
        return r;
    endfunction

    function automatic t_stim_row open_row(input logic [OP_W-1:0] op,
                                           input logic [ADDR_W-1:0] addr);
        t_stim_row r;
        r = '{1'b0, CFG_SET_BITS, '0, op, addr, 1'b0, OUT_HIT, 1'b0};
        return r;
    endfunction

    initial begin : stimulus
        logic [ADDR_W-1:0] tag_pool [12];
        logic [63:0]       wide;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        int s_eff;
        int w_eff;
        int bb;
        int nsets;
        int set_pick;
        int pick;
        int rand_done;

        // reset geometry: one set, one way, the tag is the whole address
        dir_rows.push_back(known_row(OP_LOAD, 32'h0000_0000, OUT_FILL, 1'b0));
        dir_rows.push_back(known_row(OP_LOAD, 32'h0000_0000, OUT_HIT, 1'b0));
        dir_rows.push_back(known_row(OP_STORE, 32'hffff_ffff, OUT_EVICT, 1'b0));
        dir_rows.push_back(known_row(OP_MODIFY, 32'hffff_ffff, OUT_HIT, 1'b1));
        dir_rows.push_back(known_row(OP_MODIFY, 32'h1234_5678, OUT_EVICT, 1'b1));
        dir_rows.push_back(known_row(OP_UNUSED, 32'ha5a5_a5a5, OUT_HIT, 1'b0));
        dir_rows.push_back(known_row(OP_LOAD, 32'h1234_5678, OUT_HIT, 1'b0));
        // set bits clamp to 6, way count 0 acts as 1; tag bits fall off the top
        dir_rows.push_back(cfg_row(CFG_SET_BITS, 5'd7));
        dir_rows.push_back(cfg_row(CFG_BLOCK_BITS, 5'd26));
        dir_rows.push_back(cfg_row(CFG_WAYS, 5'd0));
        dir_rows.push_back(known_row(OP_LOAD, 32'hfc00_0000, OUT_FILL, 1'b0));
        dir_rows.push_back(known_row(OP_STORE, 32'hfc00_00ff, OUT_HIT, 1'b0));
        dir_rows.push_back(known_row(OP_MODIFY, 32'h0400_0000, OUT_FILL, 1'b1));
        // offset of 31: only address bit 31 reaches the set index
        dir_rows.push_back(cfg_row(CFG_WAYS, 5'd15));
        dir_rows.push_back(cfg_row(CFG_BLOCK_BITS, 5'd31));
        dir_rows.push_back(known_row(OP_LOAD, 32'h8000_0000, OUT_HIT, 1'b0));
        dir_rows.push_back(known_row(OP_LOAD, 32'h7fff_ffff, OUT_FILL, 1'b0));
        // two-way LRU walk in set 0, after one load to set 1
        dir_rows.push_back(cfg_row(CFG_SET_BITS, 5'd2));
        dir_rows.push_back(cfg_row(CFG_BLOCK_BITS, 5'd4));
        dir_rows.push_back(cfg_row(CFG_WAYS, 5'd2));
        dir_rows.push_back(open_row(OP_LOAD, 32'h0000_0010));
        dir_rows.push_back(open_row(OP_LOAD, 32'h0000_1000));
        dir_rows.push_back(open_row(OP_LOAD, 32'h0000_2000));
        dir_rows.push_back(open_row(OP_STORE, 32'h0000_1000));
        dir_rows.push_back(open_row(OP_LOAD, 32'h0000_3000));
        dir_rows.push_back(open_row(OP_LOAD, 32'h0000_2000));
        dir_rows.push_back(open_row(OP_MODIFY, 32'h0000_1000));
        dir_rows.push_back(open_row(OP_STORE, 32'h0000_3000));
        dir_rows.push_back(open_row(OP_LOAD, 32'hffff_ffc0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg)
                apply_reg(dir_rows[n].cfg_index, dir_rows[n].cfg_data);
            else
                send_access(dir_rows[n].op, dir_rows[n].addr, dir_rows[n].typed,
                            dir_rows[n].outcome, dir_rows[n].second_hit);
        end

        rand_done = 0;
        for (int g = 0; g < NUM_GEOMETRIES; g++) begin
            apply_reg(CFG_SET_BITS, CFG_DATA_W'(geo_set[g]));
            apply_reg(CFG_BLOCK_BITS, CFG_DATA_W'(geo_block[g]));
            apply_reg(CFG_WAYS, CFG_DATA_W'(geo_ways[g]));
            s_eff = (geo_set[g] > SET_LIMIT) ? SET_LIMIT : geo_set[g];
            w_eff = (geo_ways[g] == 0) ? 1 : ((geo_ways[g] > WAY_LIMIT) ? WAY_LIMIT
                                                                        : geo_ways[g]);
            bb = geo_block[g];
            nsets = 1 << s_eff;
            foreach (tag_pool[t])
                tag_pool[t] = $urandom;
            for (int k = 0; k < RAND_PER_GEOMETRY; k++) begin
                if (rand_done < 630) begin
                    send_idle_pct = 18;
                    recv_idle_pct = 64;
                end else if (rand_done < 1260) begin
                    send_idle_pct = 64;
                    recv_idle_pct = 18;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (g == 4 && k == RAND_PER_GEOMETRY / 2)
                    wait_drained();
                pick = $urandom_range(99);
                if (pick < 5)
                    op = OP_UNUSED;
                else if (pick < 35)
                    op = OP_LOAD;
                else if (pick < 65)
                    op = OP_STORE;
                else
                    op = OP_MODIFY;
                if ($urandom_range(9) == 0) begin
                    addr = $urandom;
                end else begin
                    // few sets and a small tag pool so lines get reused and evicted
                    if ($urandom_range(3) == 0)
                        set_pick = $urandom_range(nsets - 1);
                    else
                        set_pick = $urandom_range(((nsets > 4) ? 4 : nsets) - 1);
                    wide = ({32'd0, tag_pool[$urandom_range(w_eff + 2)]} << (s_eff + bb))
                         | (64'(set_pick) << bb)
                         | 64'($urandom & ((32'd1 << bb) - 32'd1));
                    addr = wide[ADDR_W-1:0];
                end
                send_access(op, addr, 1'b0, OUT_HIT, 1'b0);
                rand_done++;
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results over %0d cache geometries, reset one included.",
                 checked_count, NUM_GEOMETRIES + 4);
        $display("First lookups: %0d hits, %0d fills, %0d evictions; %0d modify rehits.",
                 hit_seen, fill_seen, evict_seen, second_seen);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
